### hw/rtl/jvl_pkg.sv
// jvl_pkg: widths, configuration register codes and pipeline stage types
// for the joint velocity limiter core
// no dependencies
package jvl_pkg;

    localparam int SPEED_BITS = 16;
    localparam int ANGLE_BITS = 16;

    localparam int NUM_JOINTS = 5;
    localparam int NUM_ANGLES = 3;
    localparam int INV_JOINT  = 2;

    // scaled magnitude never exceeds the limit, so the quotient fits below the sign bit
    localparam int QUO_BITS   = SPEED_BITS - 1;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = (QUO_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int QUO_SLOTS  = DIV_STAGES * DIV_STEP;
    localparam int PROD_BITS  = 2 * SPEED_BITS - 1;
    localparam int DIST_BITS  = ANGLE_BITS + 2;

    // front, divider entry, divider stages, output register
    localparam int NUM_STAGES = DIV_STAGES + 3;
    localparam int STG_OUT    = NUM_STAGES - 1;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (SPEED_BITS > ANGLE_BITS) ? SPEED_BITS : ANGLE_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_LIMIT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MARGIN      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_LIMIT_0 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_LIMIT_1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_LIMIT_2 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPAN_0      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPAN_1      = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPAN_2      = 3'd7;

    typedef logic        [SPEED_BITS-1:0] spd_t;
    typedef logic signed [SPEED_BITS-1:0] sspd_t;
    typedef logic        [SPEED_BITS:0]   wide_t;
    typedef logic signed [DIST_BITS-1:0]  dst_t;
    typedef logic        [PROD_BITS-1:0]  prod_t;
    typedef logic        [QUO_SLOTS-1:0]  quo_t;

    typedef struct packed {
        logic [NUM_JOINTS-1:0][SPEED_BITS-1:0] sp;
        logic [NUM_JOINTS-1:0][SPEED_BITS-1:0] mag;
        logic [NUM_ANGLES-1:0][DIST_BITS-1:0]  up;
        logic [NUM_ANGLES-1:0][DIST_BITS-1:0]  dn;
        logic                                  angles_valid;
        logic                                  halt;
    } front_t;

    typedef struct packed {
        logic [NUM_JOINTS-1:0][SPEED_BITS-1:0] rem;
        logic [NUM_JOINTS-1:0][QUO_SLOTS-1:0]  quo;
        logic [SPEED_BITS-1:0]                 dvs;
        logic [NUM_JOINTS-1:0][SPEED_BITS-1:0] sp;
        logic                                  scaled;
        logic                                  near;
        logic                                  halt;
    } divw_t;

    typedef struct packed {
        logic [NUM_JOINTS-1:0][SPEED_BITS-1:0] dem;
        logic                                  was_scaled;
        logic                                  travel_stop;
        logic                                  halted;
    } res_t;

endpackage

### hw/rtl/joint_velocity_limiter_core.sv
// joint_velocity_limiter_core: speed limiting, travel-end protection and
// emergency stop for a five-joint speed command
// depends on jvl_pkg
//
// usage:
//   command words enter on in_valid/in_stall, result words leave on
//   out_valid/out_stall; a word moves at a clock edge with valid high and
//   stall low. registers are written over cfg_valid/cfg_ready/cfg_index/
//   cfg_data; the user must do so only while no word is in flight, which
//   the block does not enforce. cfg_ready is always high. a word passes the
//   front stage, the divider entry with the speed-limit multiply, 5 per-bit
//   restoring divider stages of 3 quotient bits each and the output register;
//   one word is taken every cycle while in_stall is low, as the chain is pipelined.
//   every stage holds its own valid bit; a stalled stage only blocks the ones
//   behind it, so empty stages fill up while the output waits, and in_stall
//   rises only when all 8 stages hold a word and out_stall is high.
//   reset empties the pipeline and sets speed_limit to its maximum, margin to
//   zero, lower limits to the most negative position and spans to all ones.
//   with halt set the demands are zero and halted is high; when angles_valid
//   is high and one of joints 0 to 2 moves toward a travel end inside the
//   margin without halt, demands are zero and travel_stop is high.
module joint_velocity_limiter_core (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [jvl_pkg::SPEED_BITS-1:0]  speed_0,
    input  logic signed [jvl_pkg::SPEED_BITS-1:0]  speed_1,
    input  logic signed [jvl_pkg::SPEED_BITS-1:0]  speed_2,
    input  logic signed [jvl_pkg::SPEED_BITS-1:0]  speed_3,
    input  logic signed [jvl_pkg::SPEED_BITS-1:0]  speed_4,
    input  logic signed [jvl_pkg::ANGLE_BITS-1:0]  angle_0,
    input  logic signed [jvl_pkg::ANGLE_BITS-1:0]  angle_1,
    input  logic signed [jvl_pkg::ANGLE_BITS-1:0]  angle_2,
    input  logic                                   angles_valid,
    input  logic                                   halt,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [jvl_pkg::SPEED_BITS-1:0]  demand_0,
    output logic signed [jvl_pkg::SPEED_BITS-1:0]  demand_1,
    output logic signed [jvl_pkg::SPEED_BITS-1:0]  demand_2,
    output logic signed [jvl_pkg::SPEED_BITS-1:0]  demand_3,
    output logic signed [jvl_pkg::SPEED_BITS-1:0]  demand_4,
    output logic                                   was_scaled,
    output logic                                   travel_stop,
    output logic                                   halted,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [jvl_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [jvl_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    // configuration registers
    logic        [jvl_pkg::SPEED_BITS-2:0] speed_limit_reg;
    logic        [jvl_pkg::ANGLE_BITS-2:0] margin_reg;
    logic signed [jvl_pkg::ANGLE_BITS-1:0] low_limit_reg [jvl_pkg::NUM_ANGLES];
    logic        [jvl_pkg::ANGLE_BITS-1:0] span_reg      [jvl_pkg::NUM_ANGLES];

    // pipeline control
    logic [jvl_pkg::NUM_STAGES-1:0] vld_reg;
    logic [jvl_pkg::NUM_STAGES-1:0] vld_next;
    logic [jvl_pkg::NUM_STAGES-1:0] adv;

    // pipeline payload
    jvl_pkg::front_t front_reg;
    jvl_pkg::front_t front_next;
    jvl_pkg::divw_t  div_reg  [0:jvl_pkg::DIV_STAGES];
    jvl_pkg::divw_t  div0_next;
    jvl_pkg::divw_t  div_next [1:jvl_pkg::DIV_STAGES];
    jvl_pkg::res_t   out_reg;
    jvl_pkg::res_t   out_next;

    logic signed [jvl_pkg::SPEED_BITS-1:0] sp_in  [jvl_pkg::NUM_JOINTS];
    logic signed [jvl_pkg::ANGLE_BITS-1:0] pos_in [jvl_pkg::NUM_ANGLES];

    assign cfg_ready = 1'b1;

    assign sp_in[0]  = speed_0;
    assign sp_in[1]  = speed_1;
    assign sp_in[2]  = speed_2;
    assign sp_in[3]  = speed_3;
    assign sp_in[4]  = speed_4;
    assign pos_in[0] = angle_0;
    assign pos_in[1] = angle_1;
    assign pos_in[2] = angle_2;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= '1;
            margin_reg      <= '0;
            for (int i = 0; i < jvl_pkg::NUM_ANGLES; i++)
            begin
                low_limit_reg[i] <= {1'b1, {(jvl_pkg::ANGLE_BITS-1){1'b0}}};
                span_reg[i]      <= '1;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jvl_pkg::CFG_SPEED_LIMIT: speed_limit_reg  <= cfg_data[jvl_pkg::SPEED_BITS-2:0];
                jvl_pkg::CFG_MARGIN:      margin_reg       <= cfg_data[jvl_pkg::ANGLE_BITS-2:0];
                jvl_pkg::CFG_LOW_LIMIT_0: low_limit_reg[0] <= cfg_data[jvl_pkg::ANGLE_BITS-1:0];
                jvl_pkg::CFG_LOW_LIMIT_1: low_limit_reg[1] <= cfg_data[jvl_pkg::ANGLE_BITS-1:0];
                jvl_pkg::CFG_LOW_LIMIT_2: low_limit_reg[2] <= cfg_data[jvl_pkg::ANGLE_BITS-1:0];
                jvl_pkg::CFG_SPAN_0:      span_reg[0]      <= cfg_data[jvl_pkg::ANGLE_BITS-1:0];
                jvl_pkg::CFG_SPAN_1:      span_reg[1]      <= cfg_data[jvl_pkg::ANGLE_BITS-1:0];
                jvl_pkg::CFG_SPAN_2:      span_reg[2]      <= cfg_data[jvl_pkg::ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[jvl_pkg::STG_OUT] = !vld_reg[jvl_pkg::STG_OUT] || !out_stall;
        for (int k = jvl_pkg::STG_OUT - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < jvl_pkg::NUM_STAGES; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[jvl_pkg::STG_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // front stage: magnitudes and exact distances to both travel ends
    always_comb
    begin
        front_next = '0;
        for (int j = 0; j < jvl_pkg::NUM_JOINTS; j++)
        begin
            front_next.sp[j]  = sp_in[j];
            front_next.mag[j] = sp_in[j][jvl_pkg::SPEED_BITS-1] ?
                                jvl_pkg::spd_t'(-sp_in[j]) : jvl_pkg::spd_t'(sp_in[j]);
        end
        for (int i = 0; i < jvl_pkg::NUM_ANGLES; i++)
        begin
            front_next.up[i] = jvl_pkg::dst_t'(low_limit_reg[i])
                             + jvl_pkg::dst_t'(span_reg[i])
                             - jvl_pkg::dst_t'(pos_in[i]);
            front_next.dn[i] = jvl_pkg::dst_t'(pos_in[i])
                             - jvl_pkg::dst_t'(low_limit_reg[i]);
        end
        front_next.angles_valid = angles_valid;
        front_next.halt         = halt;
    end

    // divider entry: largest magnitude, limit products, margin check
    always_comb
    begin
        jvl_pkg::spd_t  mx;
        jvl_pkg::prod_t prod;
        logic           lim_zero;
        logic           dir_pos;
        logic           dir_neg;
        logic           swap;
        logic           near;

        swap = 1'b0;
        mx = front_reg.mag[0];
        for (int j = 1; j < jvl_pkg::NUM_JOINTS; j++)
        begin
            if (front_reg.mag[j] > mx)
            begin
                mx = front_reg.mag[j];
            end
        end

        div0_next        = '0;
        div0_next.dvs    = mx;
        div0_next.sp     = front_reg.sp;
        div0_next.halt   = front_reg.halt;
        div0_next.scaled = mx > jvl_pkg::spd_t'(speed_limit_reg);

        for (int j = 0; j < jvl_pkg::NUM_JOINTS; j++)
        begin
            prod = jvl_pkg::prod_t'(front_reg.mag[j]) * jvl_pkg::prod_t'(speed_limit_reg);
            div0_next.rem[j] = jvl_pkg::spd_t'(prod >> jvl_pkg::QUO_SLOTS);
            div0_next.quo[j] = prod[jvl_pkg::QUO_SLOTS-1:0];
        end

        // a zero limit with scaling leaves every joint standing still
        lim_zero = (speed_limit_reg == '0);
        near     = 1'b0;
        for (int i = 0; i < jvl_pkg::NUM_ANGLES; i++)
        begin
            dir_neg = front_reg.sp[i][jvl_pkg::SPEED_BITS-1];
            dir_pos = !dir_neg && (front_reg.sp[i] != '0);
            if (div0_next.scaled && lim_zero)
            begin
                dir_neg = 1'b0;
                dir_pos = 1'b0;
            end
            if (i == jvl_pkg::INV_JOINT)
            begin
                swap    = dir_pos;
                dir_pos = dir_neg;
                dir_neg = swap;
            end
            if (($signed(front_reg.up[i]) < jvl_pkg::dst_t'(margin_reg) && dir_pos) ||
                ($signed(front_reg.dn[i]) < jvl_pkg::dst_t'(margin_reg) && dir_neg))
            begin
                near = 1'b1;
            end
        end
        div0_next.near = near && front_reg.angles_valid;
    end

    // restoring divider, three quotient bits per stage
    always_comb
    begin
        jvl_pkg::divw_t cur;
        jvl_pkg::wide_t t;
        jvl_pkg::wide_t dw;
        logic           qbit;

        for (int s = 1; s <= jvl_pkg::DIV_STAGES; s++)
        begin
            cur = div_reg[s-1];
            dw  = {1'b0, cur.dvs};
            for (int j = 0; j < jvl_pkg::NUM_JOINTS; j++)
            begin
                for (int k = 0; k < jvl_pkg::DIV_STEP; k++)
                begin
                    t    = {cur.rem[j], cur.quo[j][jvl_pkg::QUO_SLOTS-1]};
                    qbit = (t >= dw);
                    if (qbit)
                    begin
                        t = t - dw;
                    end
                    cur.rem[j] = t[jvl_pkg::SPEED_BITS-1:0];
                    cur.quo[j] = {cur.quo[j][jvl_pkg::QUO_SLOTS-2:0], qbit};
                end
            end
            div_next[s] = cur;
        end
    end

    // output word
    always_comb
    begin
        jvl_pkg::divw_t fin;
        jvl_pkg::spd_t  q;

        fin      = div_reg[jvl_pkg::DIV_STAGES];
        out_next = '0;
        for (int j = 0; j < jvl_pkg::NUM_JOINTS; j++)
        begin
            q = jvl_pkg::spd_t'(fin.quo[j][jvl_pkg::QUO_BITS-1:0]);
            if (fin.halt || fin.near)
            begin
                out_next.dem[j] = '0;
            end
            else if (fin.scaled)
            begin
                out_next.dem[j] = fin.sp[j][jvl_pkg::SPEED_BITS-1] ? jvl_pkg::spd_t'(-q) : q;
            end
            else
            begin
                out_next.dem[j] = fin.sp[j];
            end
        end
        out_next.was_scaled  = fin.scaled && !fin.halt;
        out_next.travel_stop = fin.near && !fin.halt;
        out_next.halted      = fin.halt;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            front_reg <= front_next;
        end
        if (adv[1])
        begin
            div_reg[0] <= div0_next;
        end
        for (int s = 1; s <= jvl_pkg::DIV_STAGES; s++)
        begin
            if (adv[s+1])
            begin
                div_reg[s] <= div_next[s];
            end
        end
        if (adv[jvl_pkg::STG_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign demand_0    = $signed(out_reg.dem[0]);
    assign demand_1    = $signed(out_reg.dem[1]);
    assign demand_2    = $signed(out_reg.dem[2]);
    assign demand_3    = $signed(out_reg.dem[3]);
    assign demand_4    = $signed(out_reg.dem[4]);
    assign was_scaled  = out_reg.was_scaled;
    assign travel_stop = out_reg.travel_stop;
    assign halted      = out_reg.halted;

`ifndef SYNTHESIS
    // emergency words carry nothing but the halted flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halted |->
            demand_0 == '0 && demand_1 == '0 && demand_2 == '0 &&
            demand_3 == '0 && demand_4 == '0 && !was_scaled && !travel_stop)
        else $error("halted word with nonzero demand or flags");

    // travel-end protection zeroes every demand
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && travel_stop |->
            demand_0 == '0 && demand_1 == '0 && demand_2 == '0 &&
            demand_3 == '0 && demand_4 == '0 && !halted)
        else $error("travel-stop word with nonzero demand");

    // a blocked front stage keeps its word
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && !adv[1] |=> vld_reg[0] && $stable(front_reg))
        else $error("front stage word lost under stall");

    // input is held off only when every stage is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg) && out_stall)
        else $error("input stalled with a free pipeline slot");
`endif

endmodule
